[hw/rtl/hcbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hcbb_pkg;

    // Frame geometry limits; the row and column counters saturate one below these.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int PIX_W      = 8;
    localparam int OUT_W      = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Bit-serial divider used for both reciprocals (saturation and hue).
    localparam int DIV_NUM_W  = 21;
    localparam int DIV_DEN_W  = 9;
    localparam int DIV_Q_W    = 20;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [COL_W-1:0]     t_col;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [OUT_W-1:0]     t_coord;
    typedef logic [DIV_NUM_W-1:0] t_div_num;
    typedef logic [DIV_DEN_W-1:0] t_div_den;
    typedef logic [DIV_Q_W-1:0]   t_div_quot;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Rounded reciprocals are (2 * N + x) / (2 * x); these are the 2 * N terms.
    localparam t_div_num SAT_NUM = 21'd2088960;
    localparam t_div_num HUE_NUM = 21'd245760;

    localparam t_col COL_MAX = t_col'(MAX_WIDTH - 1);
    localparam t_row ROW_MAX = t_row'(MAX_HEIGHT - 1);

    // Register indexes on the configuration channel.
    localparam t_cfg_idx CFG_HUE_LOW  = 3'd0;
    localparam t_cfg_idx CFG_HUE_HIGH = 3'd1;
    localparam t_cfg_idx CFG_SAT_LOW  = 3'd2;
    localparam t_cfg_idx CFG_SAT_HIGH = 3'd3;
    localparam t_cfg_idx CFG_VAL_LOW  = 3'd4;
    localparam t_cfg_idx CFG_VAL_HIGH = 3'd5;

    localparam t_pix RST_HUE_LOW  = 8'd0;
    localparam t_pix RST_HUE_HIGH = 8'd5;
    localparam t_pix RST_SAT_LOW  = 8'd100;
    localparam t_pix RST_SAT_HIGH = 8'd255;
    localparam t_pix RST_VAL_LOW  = 8'd100;
    localparam t_pix RST_VAL_HIGH = 8'd255;

    typedef enum logic {
        DIV_SAT = 1'b0,
        DIV_HUE = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     mul_s;
        logic     mul_h;
        logic     hue;
        logic     update;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic eof;
        logic out_blocked;
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/hcbb_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcbb_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  hcbb_pkg::t_div_num   i_num,
    input  hcbb_pkg::t_div_den   i_den,
    output logic                 o_done,
    output hcbb_pkg::t_div_quot  o_quot
);

    logic                 r_busy;
    logic                 r_done;
    hcbb_pkg::t_div_cnt   r_cnt;
    hcbb_pkg::t_div_num   r_num;
    hcbb_pkg::t_div_den   r_den;
    hcbb_pkg::t_div_den   r_rem;
    hcbb_pkg::t_div_quot  r_quot;

    logic [hcbb_pkg::DIV_DEN_W:0] rem_sh;
    logic [hcbb_pkg::DIV_DEN_W:0] rem_diff;
    logic                         q_bit;
    hcbb_pkg::t_div_den           n_rem;

    // Restoring division, one quotient bit per cycle. For a divisor of two or more the
    // leading quotient bit is always zero, so it simply falls off the top of r_quot.
    always_comb begin
        rem_sh   = {r_rem, r_num[hcbb_pkg::DIV_NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        q_bit    = (rem_sh >= {1'b0, r_den});
        n_rem    = q_bit ? rem_diff[hcbb_pkg::DIV_DEN_W-1:0]
                         : rem_sh[hcbb_pkg::DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hcbb_pkg::t_div_cnt'(hcbb_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[hcbb_pkg::DIV_NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[hcbb_pkg::DIV_Q_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done)
        else $error("divider left busy without signalling done");

endmodule

`default_nettype wire

[hw/rtl/hcbb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcbb_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  hcbb_pkg::t_status  i_status,
    output hcbb_pkg::t_cmd     o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_DIV_S_GO   = 9'b000000010,
        S_DIV_S_WAIT = 9'b000000100,
        S_MUL_S      = 9'b000001000,
        S_DIV_H_GO   = 9'b000010000,
        S_DIV_H_WAIT = 9'b000100000,
        S_MUL_H      = 9'b001000000,
        S_HUE        = 9'b010000000,
        S_UPDATE     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = hcbb_pkg::DIV_SAT;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV_S_GO;
                end
            end
            S_DIV_S_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hcbb_pkg::DIV_SAT;
                n_state         = S_DIV_S_WAIT;
            end
            S_DIV_S_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_MUL_S;
                end
            end
            S_MUL_S: begin
                o_cmd.mul_s = 1'b1;
                n_state     = S_DIV_H_GO;
            end
            S_DIV_H_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hcbb_pkg::DIV_HUE;
                n_state         = S_DIV_H_WAIT;
            end
            S_DIV_H_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_MUL_H;
                end
            end
            S_MUL_H: begin
                o_cmd.mul_h = 1'b1;
                n_state     = S_HUE;
            end
            S_HUE: begin
                o_cmd.hue = 1'b1;
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                // A frame result has to wait while the previous one is still stalled.
                if (!(i_status.eof && i_status.out_blocked)) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hcbb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcbb_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  hcbb_pkg::t_cmd                        i_cmd,
    output hcbb_pkg::t_status                     o_status,
    input  hcbb_pkg::t_pix                        i_blue,
    input  hcbb_pkg::t_pix                        i_green,
    input  hcbb_pkg::t_pix                        i_red,
    input  wire                                   i_eol,
    input  wire                                   i_eof,
    input  wire                                   i_cfg_valid,
    input  hcbb_pkg::t_cfg_idx                    i_cfg_index,
    input  hcbb_pkg::t_pix                        i_cfg_data,
    output logic                                  o_m_valid,
    input  wire                                   i_m_ready,
    output logic [hcbb_pkg::OUT_TDATA_W-1:0]      o_m_data,
    output logic                                  o_m_found
);

    // Configuration.
    hcbb_pkg::t_pix r_hue_low, r_hue_high, r_sat_low, r_sat_high, r_val_low, r_val_high;

    // Current pixel and intermediate results.
    hcbb_pkg::t_pix     r_blue, r_green, r_red;
    logic               r_eol, r_eof;
    hcbb_pkg::t_pix     r_sat;
    logic signed [28:0] r_prod;
    logic               r_match;

    // Frame state.
    hcbb_pkg::t_col r_col, r_min_col, r_max_col;
    hcbb_pkg::t_row r_row, r_min_row, r_max_row;
    logic           r_any;

    // Result register.
    logic             r_out_valid;
    logic             r_out_found;
    hcbb_pkg::t_coord r_out_left, r_out_right, r_out_top, r_out_bottom, r_out_cx, r_out_cy;

    hcbb_pkg::t_pix      v, mn, d;
    logic signed [11:0]  sb, sg, sr, sd, raw;
    hcbb_pkg::t_div_num  div_num;
    hcbb_pkg::t_div_den  div_den;
    hcbb_pkg::t_div_quot quot;
    logic                div_done;
    logic [28:0]         sat_sum;
    logic signed [28:0]  raw_x, quot_x, prod;
    logic signed [28:0]  hue_t;
    logic signed [8:0]   hue_h;
    logic [8:0]          hue_w;
    hcbb_pkg::t_pix      hue;
    logic                match;

    hcbb_pkg::t_col n_col, n_min_col, n_max_col;
    hcbb_pkg::t_row n_row, n_min_row, n_max_row;
    logic           n_any;
    logic [hcbb_pkg::COL_W:0] cx_sum;
    logic [hcbb_pkg::ROW_W:0] cy_sum;

    // Value, chroma and the raw hue numerator of the held pixel.
    always_comb begin
        v = r_blue;
        if (r_green > v) v = r_green;
        if (r_red > v)   v = r_red;
        mn = r_blue;
        if (r_green < mn) mn = r_green;
        if (r_red < mn)   mn = r_red;
        d  = v - mn;
        sb = $signed({4'b0000, r_blue});
        sg = $signed({4'b0000, r_green});
        sr = $signed({4'b0000, r_red});
        sd = $signed({4'b0000, d});
        if (v == r_red) begin
            raw = sg - sb;
        end else if (v == r_green) begin
            raw = sb - sr + (sd <<< 1);
        end else begin
            raw = sr - sg + (sd <<< 2);
        end
    end

    always_comb begin
        if (i_cmd.div_sel == hcbb_pkg::DIV_HUE) begin
            div_num = hcbb_pkg::HUE_NUM + hcbb_pkg::t_div_num'(d);
            div_den = {d, 1'b0};
        end else begin
            div_num = hcbb_pkg::SAT_NUM + hcbb_pkg::t_div_num'(v);
            div_den = {v, 1'b0};
        end
    end

    hcbb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // A zero divisor leaves an all-ones quotient, but chroma and the raw hue are
    // then zero as well, so both products come out as zero.
    always_comb begin
        sat_sum = 29'(d) * 29'(quot) + 29'd2048;
        raw_x   = {{17{raw[11]}}, raw};
        quot_x  = $signed({9'b0, quot});
        prod    = raw_x * quot_x;
        hue_t   = r_prod + 29'sd2048;
        hue_h   = hue_t[20:12];
        hue_w   = hue_h[8] ? (hue_h + 9'sd180) : hue_h;
        hue     = hue_w[7:0];
        match   = (hue >= r_hue_low) && (hue <= r_hue_high) &&
                  (r_sat >= r_sat_low) && (r_sat <= r_sat_high) &&
                  (v >= r_val_low) && (v <= r_val_high);
    end

    // Box including the held pixel, and the position of the next pixel.
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_any     = r_any | r_match;
        if (r_match) begin
            if (!r_any) begin
                n_min_col = r_col;
                n_max_col = r_col;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (r_col < r_min_col) n_min_col = r_col;
                if (r_col > r_max_col) n_max_col = r_col;
                if (r_row < r_min_row) n_min_row = r_row;
                if (r_row > r_max_row) n_max_row = r_row;
            end
        end
        n_col = r_col;
        n_row = r_row;
        if (r_eol) begin
            n_col = '0;
            if (r_row < hcbb_pkg::ROW_MAX) n_row = r_row + 1'b1;
        end else if (r_col < hcbb_pkg::COL_MAX) begin
            n_col = r_col + 1'b1;
        end
        cx_sum = {1'b0, n_min_col} + {1'b0, n_max_col};
        cy_sum = {1'b0, n_min_row} + {1'b0, n_max_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= hcbb_pkg::RST_HUE_LOW;
            r_hue_high <= hcbb_pkg::RST_HUE_HIGH;
            r_sat_low  <= hcbb_pkg::RST_SAT_LOW;
            r_sat_high <= hcbb_pkg::RST_SAT_HIGH;
            r_val_low  <= hcbb_pkg::RST_VAL_LOW;
            r_val_high <= hcbb_pkg::RST_VAL_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hcbb_pkg::CFG_HUE_LOW:  r_hue_low  <= i_cfg_data;
                hcbb_pkg::CFG_HUE_HIGH: r_hue_high <= i_cfg_data;
                hcbb_pkg::CFG_SAT_LOW:  r_sat_low  <= i_cfg_data;
                hcbb_pkg::CFG_SAT_HIGH: r_sat_high <= i_cfg_data;
                hcbb_pkg::CFG_VAL_LOW:  r_val_low  <= i_cfg_data;
                hcbb_pkg::CFG_VAL_HIGH: r_val_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_eol   <= i_eol;
            r_eof   <= i_eof;
        end
        if (i_cmd.mul_s) begin
            r_sat <= sat_sum[19:12];
        end
        if (i_cmd.mul_h) begin
            r_prod <= prod;
        end
        if (i_cmd.hue) begin
            r_match <= match;
        end
        if (i_cmd.update && r_eof) begin
            r_out_found  <= n_any;
            r_out_left   <= hcbb_pkg::t_coord'(n_min_col);
            r_out_right  <= hcbb_pkg::t_coord'(n_max_col);
            r_out_top    <= hcbb_pkg::t_coord'(n_min_row);
            r_out_bottom <= hcbb_pkg::t_coord'(n_max_row);
            r_out_cx     <= hcbb_pkg::t_coord'(cx_sum[hcbb_pkg::COL_W:1]);
            r_out_cy     <= hcbb_pkg::t_coord'(cy_sum[hcbb_pkg::ROW_W:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_min_col   <= '0;
            r_max_col   <= '0;
            r_min_row   <= '0;
            r_max_row   <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                if (r_eof) begin
                    r_col     <= '0;
                    r_row     <= '0;
                    r_min_col <= '0;
                    r_max_col <= '0;
                    r_min_row <= '0;
                    r_max_row <= '0;
                    r_any     <= 1'b0;
                end else begin
                    r_col     <= n_col;
                    r_row     <= n_row;
                    r_min_col <= n_min_col;
                    r_max_col <= n_max_col;
                    r_min_row <= n_min_row;
                    r_max_row <= n_max_row;
                    r_any     <= n_any;
                end
            end
            if (i_cmd.update && r_eof) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.div_done    = div_done;
        o_status.eof         = r_eof;
        o_status.out_blocked = r_out_valid & ~i_m_ready;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_found = r_out_found;
    assign o_m_data  = {4'b0000, r_out_cy, r_out_cx, r_out_bottom, r_out_top,
                        r_out_right, r_out_left};

    a_empty_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_min_col == '0 && r_max_col == '0 &&
                    r_min_row == '0 && r_max_row == '0))
        else $error("box bounds not zero while no pixel has matched");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
        else $error("box bounds out of order");

    a_result_from_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && $past(i_rst_n)) |-> $past(i_cmd.update && r_eof))
        else $error("result raised without a frame end");

endmodule

`default_nettype wire

[hw/rtl/hsv_color_blob_bounding_box_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                          Word
// s_axis       in         i_s_axis_tvalid / o_s_axis_tready  one BGR pixel with line/frame marks
// m_axis       out        o_m_axis_tvalid / i_m_axis_tready  one bounding box per frame
// cfg          in         i_cfg_valid / o_cfg_ready          one threshold register
//
// A pixel is taken only once the previous one is fully processed, which includes two
// 21-step passes through the single bit-serial reciprocal divider.
// Reset is synchronous and active low; it restores the default thresholds and clears
// the frame state. The result register decouples the two sides: pixels keep flowing
// while a box waits, and only a frame-end pixel stalls if the previous box is still held.

module hsv_color_blob_bounding_box_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // blue [7:0], green [15:8], red [23:16]
    input  wire  [hcbb_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // end_of_line [0]
    input  wire  [0:0]                         i_s_axis_tuser,
    input  wire                                i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // left [9:0], right [19:10], top [29:20], bottom [39:30], center_x [49:40],
    // center_y [59:50], zeros above
    output logic [hcbb_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // found [0]
    output logic [0:0]                         o_m_axis_tuser,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [hcbb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [hcbb_pkg::PIX_W-1:0]         i_cfg_data
);

    hcbb_pkg::t_cmd    cmd;
    hcbb_pkg::t_status status;
    logic              found;

    hcbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hcbb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_blue      (i_s_axis_tdata[7:0]),
        .i_green     (i_s_axis_tdata[15:8]),
        .i_red       (i_s_axis_tdata[23:16]),
        .i_eol       (i_s_axis_tuser[0]),
        .i_eof       (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_found   (found)
    );

    // Threshold writes are always accepted and are registered directly.
    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tuser = found;

endmodule

`default_nettype wire
